// File: src/sbbtg_pkg.sv
// Shared constants, register codes and types for the smoothed bang-bang tilt guard.
// Used by the register file, the decision logic, the top level and the checker.
package sbbtg_pkg;

  // Field and datapath widths.
  localparam int SAMPLE_W = 16;
  localparam int WEIGHT_W = 16;
  localparam int LIMIT_W  = 15;
  localparam int PROD_W   = 32;
  localparam int NUM_TAPS_MAX = 5;
  localparam int SUM_W    = PROD_W + $clog2(NUM_TAPS_MAX);
  localparam int FRAC_SHIFT = 15;
  localparam int SMOOTH_W = SUM_W - FRAC_SHIFT;

  // Default tap count of the smoothing filter.
  localparam int WINDOW_DEFAULT = 5;

  // Configuration port.
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  // Register reset values.
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd6554;
  localparam logic [LIMIT_W-1:0]  TILT_RESET   = 15'd2048;
  localparam logic [LIMIT_W-1:0]  RATE_RESET   = 15'd38;
  localparam logic [LIMIT_W-1:0]  LEVEL_RESET  = 15'd128;

  // Register indexes, byte address is four times the index.
  typedef enum logic [2:0] {
    REG_WEIGHT_0     = 3'd0,
    REG_WEIGHT_1     = 3'd1,
    REG_WEIGHT_2     = 3'd2,
    REG_WEIGHT_3     = 3'd3,
    REG_WEIGHT_4     = 3'd4,
    REG_TILT_LIMIT   = 3'd5,
    REG_RATE_LIMIT   = 3'd6,
    REG_SIGNAL_LEVEL = 3'd7
  } reg_idx_t;

  // Configuration bundle handed from the register file to the datapath.
  typedef struct packed {
    logic [NUM_TAPS_MAX-1:0][WEIGHT_W-1:0] weight;
    logic [LIMIT_W-1:0] tilt_limit;
    logic [LIMIT_W-1:0] rate_limit;
    logic [LIMIT_W-1:0] signal_level;
  } cfg_t;

endpackage

// File: src/sbbtg_regs.sv
// APB-style configuration registers of the tilt guard.
// Depends on sbbtg_pkg for register codes, reset values and cfg_t.
module sbbtg_regs import sbbtg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  // Register writes; the low address bits are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TAPS_MAX; i++) begin
        cfg.weight[i] <= WEIGHT_RESET;
      end
      cfg.tilt_limit   <= TILT_RESET;
      cfg.rate_limit   <= RATE_RESET;
      cfg.signal_level <= LEVEL_RESET;
    end else if (wr_en) begin
      unique case (idx) inside
        REG_WEIGHT_0, REG_WEIGHT_1, REG_WEIGHT_2, REG_WEIGHT_3, REG_WEIGHT_4: begin
          cfg.weight[idx] <= pwdata[WEIGHT_W-1:0];
        end
        REG_TILT_LIMIT:   cfg.tilt_limit   <= pwdata[LIMIT_W-1:0];
        REG_RATE_LIMIT:   cfg.rate_limit   <= pwdata[LIMIT_W-1:0];
        REG_SIGNAL_LEVEL: cfg.signal_level <= pwdata[LIMIT_W-1:0];
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    unique case (idx) inside
      REG_WEIGHT_0, REG_WEIGHT_1, REG_WEIGHT_2, REG_WEIGHT_3, REG_WEIGHT_4: begin
        prdata = PDATA_W'(cfg.weight[idx]);
      end
      REG_TILT_LIMIT:   prdata = PDATA_W'(cfg.tilt_limit);
      REG_RATE_LIMIT:   prdata = PDATA_W'(cfg.rate_limit);
      REG_SIGNAL_LEVEL: prdata = PDATA_W'(cfg.signal_level);
    endcase
  end

endmodule

// File: src/sbbtg_decide.sv
// Sums the registered tap products, forms the smoothed angle and rate, and picks the drive.
// Depends on sbbtg_pkg for widths and cfg_t.
module sbbtg_decide import sbbtg_pkg::*; #(
  parameter int WINDOW = WINDOW_DEFAULT
) (
  input  logic signed [PROD_W-1:0]   prod_new  [WINDOW],
  input  logic signed [PROD_W-1:0]   prod_prev [WINDOW],
  input  logic                       full,
  input  cfg_t                       cfg,
  output logic signed [SAMPLE_W-1:0] drive
);

  logic signed [SUM_W-1:0]    sum_new;
  logic signed [SUM_W-1:0]    sum_prev;
  logic signed [SMOOTH_W-1:0] s_new;
  logic signed [SMOOTH_W-1:0] s_prev;
  logic signed [SMOOTH_W:0]   angle;
  logic signed [SMOOTH_W:0]   rate;
  logic signed [SMOOTH_W:0]   tl;
  logic signed [SMOOTH_W:0]   rl;
  logic signed [SAMPLE_W-1:0] level;
  logic                       too_high;
  logic                       too_low;

  // Full-width sums over the taps of both positions.
  always_comb begin
    sum_new  = '0;
    sum_prev = '0;
    for (int j = 0; j < WINDOW; j++) begin
      sum_new  = sum_new  + SUM_W'(prod_new[j]);
      sum_prev = sum_prev + SUM_W'(prod_prev[j]);
    end
  end

  // Floor back to Q8.8 with an arithmetic shift, then difference for the rate.
  assign s_new  = SMOOTH_W'(sum_new  >>> FRAC_SHIFT);
  assign s_prev = SMOOTH_W'(sum_prev >>> FRAC_SHIFT);
  assign angle  = (SMOOTH_W + 1)'(s_new);
  assign rate   = (SMOOTH_W + 1)'(s_new) - (SMOOTH_W + 1)'(s_prev);
  assign tl     = $signed((SMOOTH_W + 1)'(cfg.tilt_limit));
  assign rl     = $signed((SMOOTH_W + 1)'(cfg.rate_limit));
  assign level  = $signed(SAMPLE_W'(cfg.signal_level));

  // Positive excursion wins when both sides trip.
  assign too_high = (angle > tl) || (rate > rl);
  assign too_low  = (angle < -tl) || (rate < -rl);

  always_comb begin
    if (!full) begin
      drive = '0;
    end else if (too_high) begin
      drive = -level;
    end else if (too_low) begin
      drive = level;
    end else begin
      drive = '0;
    end
  end

endmodule

// File: src/smoothed_bang_bang_tilt_guard.sv
// Smoothed bang-bang tilt guard: FIR-smoothed pitch and rate against limits give a drive.
// Path: an accepted sample request goes through the product register and then the result
// register. Throughput: one sample per cycle unless the result stream stalls; tap multipliers
// sit before the product register, tap sums and limit compares before the result register.
// Reset: synchronous, clears the pipeline, the fill count and the registers to defaults.
// Depends on sbbtg_pkg, sbbtg_regs and sbbtg_decide.
module smoothed_bang_bang_tilt_guard import sbbtg_pkg::*; #(
  parameter int WINDOW = WINDOW_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  // Sample stream.
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [SAMPLE_W-1:0] s_tdata,   // [15:0] pitch_sample
  // Result stream.
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [SAMPLE_W-1:0] m_tdata,   // [15:0] drive
  output logic                m_tuser,   // [0] history_full
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  localparam int FULL_COUNT = WINDOW + 3;
  localparam int CNT_W      = $clog2(FULL_COUNT + 1);

  cfg_t cfg;

  // Older samples, newest first; entry k is k+1 samples back of an incoming one.
  logic signed [SAMPLE_W-1:0] hist [WINDOW];
  logic [CNT_W-1:0]           fill_count;

  // Product stage.
  logic                       p_valid;
  logic                       p_full;
  logic signed [PROD_W-1:0]   prod_new  [WINDOW];
  logic signed [PROD_W-1:0]   prod_prev [WINDOW];
  logic signed [PROD_W-1:0]   prod_new_next  [WINDOW];
  logic signed [PROD_W-1:0]   prod_prev_next [WINDOW];

  // Result stage.
  logic                       o_valid;
  logic signed [SAMPLE_W-1:0] o_drive;
  logic                       o_full;
  logic signed [SAMPLE_W-1:0] drive_next;

  logic accept;
  logic o_ready;
  logic p_ready;

  sbbtg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake: each stage moves when the one after it has room.
  assign o_ready  = !o_valid || m_tready;
  assign p_ready  = !p_valid || o_ready;
  assign s_tready = p_ready;
  assign accept   = s_tvalid && s_tready;

  // Tap products of the incoming request: the newest window starts at the new sample,
  // the previous window one sample older. Operands are widened to the product width
  // first so the multiply keeps every bit.
  for (genvar j = 0; j < WINDOW; j++) begin : g_tap
    logic signed [SAMPLE_W:0] w;
    logic signed [SAMPLE_W-1:0] cur;
    assign w = $signed({1'b0, cfg.weight[j]});
    if (j == 0) begin : g_first
      assign cur = $signed(s_tdata);
    end else begin : g_rest
      assign cur = hist[j-1];
    end
    assign prod_new_next[j]  = PROD_W'(cur) * PROD_W'(w);
    assign prod_prev_next[j] = PROD_W'(hist[j]) * PROD_W'(w);
  end

  // Sample history shift.
  always_ff @(posedge clk) begin
    if (accept) begin
      hist[0] <= $signed(s_tdata);
      for (int i = 1; i < WINDOW; i++) begin
        hist[i] <= hist[i-1];
      end
    end
  end

  // Fill count saturates once the history is deep enough to decide.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (accept && (fill_count < CNT_W'(FULL_COUNT))) begin
      fill_count <= fill_count + 1'b1;
    end
  end

  // Product register.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (accept) begin
      p_valid <= 1'b1;
    end else if (o_ready) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_full    <= (fill_count >= CNT_W'(FULL_COUNT - 1));
      prod_new  <= prod_new_next;
      prod_prev <= prod_prev_next;
    end
  end

  sbbtg_decide #(
    .WINDOW (WINDOW)
  ) u_decide (
    .prod_new  (prod_new),
    .prod_prev (prod_prev),
    .full      (p_full),
    .cfg       (cfg),
    .drive     (drive_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_ready) begin
      o_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready && p_valid) begin
      o_drive <= drive_next;
      o_full  <= p_full;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = o_drive;
  assign m_tuser  = o_full;

endmodule

// File: src/sbbtg_checker.sv
// Port-level checks of the tilt guard, bound to the top level.
// Depends on sbbtg_pkg for the sample width.
module sbbtg_checker import sbbtg_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [SAMPLE_W-1:0] m_tdata,
  input logic                m_tuser
);

  logic [1:0] pending;
  logic       seen_full;

  // Requests accepted but not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(s_tvalid && s_tready) - 2'(m_tvalid && m_tready);
    end
  end

  // Once a full history has been reported it stays full until reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_full <= 1'b0;
    end else if (m_tvalid && m_tready && m_tuser) begin
      seen_full <= 1'b1;
    end
  end

  a_no_result_without_request: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (pending != 2'd0) && (pending != 2'd3))
    else $error("result offered with no request outstanding");

  a_zero_until_full: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("nonzero drive before history is full");

  a_full_sticky: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && seen_full) |-> m_tuser)
    else $error("history full flag dropped");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind smoothed_bang_bang_tilt_guard sbbtg_checker u_checker (.*);

// File: test/tb_top.sv
// Self-checking testbench for the smoothed bang-bang tilt guard.
// Sends pitch samples on the slave stream under several register settings and checks
// every drive result against a scoreboard that mirrors the FIR and limit logic.
`timescale 1ns / 1ps

// One expected result of the guard.
typedef struct packed {
  logic [15:0] drive;
  logic        full;
} tilt_result_t;

// Scoreboard: tracks the sample history and register copy, predicts each drive.
class tilt_scoreboard;
  logic [15:0]        weight [5];
  logic [14:0]        tilt_lim;
  logic [14:0]        rate_lim;
  logic [14:0]        level;
  logic signed [15:0] history [8];
  int unsigned        fill;
  tilt_result_t       expected_q [$];
  int                 mismatches;

  function new();
    for (int i = 0; i < 5; i++) weight[i] = sbbtg_pkg::WEIGHT_RESET;
    tilt_lim = sbbtg_pkg::TILT_RESET;
    rate_lim = sbbtg_pkg::RATE_RESET;
    level = sbbtg_pkg::LEVEL_RESET;
    for (int i = 0; i < 8; i++) history[i] = '0;
    fill = 0;
    mismatches = 0;
  endfunction

  // Mirror a register write.
  function void set_reg(sbbtg_pkg::reg_idx_t idx, logic [31:0] value);
    case (idx)
      sbbtg_pkg::REG_WEIGHT_0, sbbtg_pkg::REG_WEIGHT_1, sbbtg_pkg::REG_WEIGHT_2,
      sbbtg_pkg::REG_WEIGHT_3, sbbtg_pkg::REG_WEIGHT_4: begin
        weight[int'(idx)] = value[15:0];
      end
      sbbtg_pkg::REG_TILT_LIMIT: tilt_lim = value[14:0];
      sbbtg_pkg::REG_RATE_LIMIT: rate_lim = value[14:0];
      sbbtg_pkg::REG_SIGNAL_LEVEL: level = value[14:0];
      default: ;
    endcase
  endfunction

  // Weighted window sum starting at the given history offset, floored by 2^15.
  function longint smooth(int offset);
    longint acc;
    acc = 0;
    for (int j = 0; j < sbbtg_pkg::WINDOW_DEFAULT; j++) begin
      acc += longint'(history[j + offset]) * longint'({1'b0, weight[j]});
    end
    return acc >>> sbbtg_pkg::FRAC_SHIFT;
  endfunction

  // An accepted sample request: shift it in and queue the expected drive.
  function void note_sample(logic [15:0] sample);
    tilt_result_t res;
    longint angle;
    longint rate;
    longint tl;
    longint rl;
    for (int i = 7; i > 0; i--) history[i] = history[i - 1];
    history[0] = sample;
    if (fill < sbbtg_pkg::WINDOW_DEFAULT + 3) fill++;
    res.full = (fill >= sbbtg_pkg::WINDOW_DEFAULT + 3);
    res.drive = '0;
    if (res.full) begin
      angle = smooth(0);
      rate = angle - smooth(1);
      tl = longint'(tilt_lim);
      rl = longint'(rate_lim);
      // The positive test wins when both directions trip.
      if (angle > tl || rate > rl) begin
        res.drive = -{1'b0, level};
      end else if (angle < -tl || rate < -rl) begin
        res.drive = {1'b0, level};
      end
    end
    expected_q.push_back(res);
  endfunction

  // Compare one accepted result with the oldest expectation.
  function void check_result(logic [15:0] drive, logic full);
    tilt_result_t exp_res;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("Unexpected result: drive %h full %b", drive, full);
      end
      return;
    end
    exp_res = expected_q.pop_front();
    if (drive !== exp_res.drive || full !== exp_res.full) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("Mismatch at %0t: drive exp %h got %h, full exp %b got %b",
                 $time, exp_res.drive, drive, exp_res.full, full);
      end
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_top;
  import sbbtg_pkg::*;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [SAMPLE_W-1:0] s_tdata;   // [15:0] pitch_sample
  logic                m_tvalid;
  logic                m_tready;
  logic [SAMPLE_W-1:0] m_tdata;   // [15:0] drive
  logic                m_tuser;   // [0] history_full
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  tilt_scoreboard sb;
  logic [31:0]    cfg_vals [8];
  bit             quiet;
  int             ready_hold;
  int             walk;
  int             walk_step;

  logic [15:0] directed_pitch [0:21] = '{
    16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h7FFF, 16'h8000, 16'h5555,
    16'd5000, 16'd5000, 16'd5000, 16'd5000, 16'd5000, 16'd3000,
    16'hEC78, 16'hEC78, 16'hEC78, 16'hEC78, 16'hEC78, 16'hF448,
    16'h0000, 16'h0000
  };

  smoothed_bang_bang_tilt_guard dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gap lengths: mostly none or short, now and then long.
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side back-pressure.
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold = ready_hold - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (!quiet) ready_hold = pick_gap();
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
  end

  // Send one sample request; called and returns at a falling edge.
  task automatic send_pitch(logic [15:0] value);
    int gap;
    gap = quiet ? 0 : pick_gap();
    s_tvalid <= 1'b1;
    s_tdata <= value;
    do @(posedge clk); while (!s_tready);
    sb.note_sample(value);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Let every outstanding result drain with the sender held off.
  task automatic drain();
    while (sb.pending() > 0) @(negedge clk);
  endtask

  // Write all eight registers from cfg_vals; called at a falling edge while idle.
  task automatic apply_config();
    reg_idx_t idx;
    for (int i = 0; i < 8; i++) begin
      idx = reg_idx_t'(i);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= cfg_vals[i];
      @(negedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      sb.set_reg(idx, cfg_vals[i]);
      @(negedge clk);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Register settings for one phase: a few fixed corners, the rest random.
  task automatic pick_config(int phase);
    logic [15:0] w;
    logic [14:0] lim;
    int r;
    for (int i = 0; i < 8; i++) begin
      if (phase == 1) begin
        w = 16'hFFFF;
        lim = 15'h7FFF;
      end else if (phase == 2) begin
        w = 16'h0000;
        lim = 15'h0000;
      end else if (phase == 3) begin
        // Plain pass-through on the newest tap with tight limits.
        w = (i == 0) ? 16'h8000 : 16'h0000;
        lim = 15'($urandom_range(0, 200));
      end else if (phase == 4) begin
        // Weights above unity gain, below twice unity.
        w = 16'($urandom_range(32769, 65535));
        lim = 15'($urandom_range(0, 32767));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) w = 16'($urandom_range(0, 8192));
        else if (r < 80) w = 16'($urandom_range(24576, 32768));
        else w = 16'($urandom_range(0, 65535));
        r = $urandom_range(0, 99);
        if (r < 50) lim = 15'($urandom_range(0, 64));
        else if (r < 80) lim = 15'($urandom_range(0, 4096));
        else lim = 15'($urandom_range(0, 32767));
      end
      if (i < 5) cfg_vals[i] = {16'($urandom_range(0, 65535)), w};
      else cfg_vals[i] = {17'($urandom_range(0, 131071)), lim};
    end
  endtask

  // Next random pitch: slow walks, values around the angle limit, or anything at all.
  function logic [15:0] next_pitch();
    int r;
    int delta;
    int tl;
    r = $urandom_range(0, 99);
    tl = int'(cfg_vals[REG_TILT_LIMIT][14:0]);
    if (r < 50) begin
      walk = walk + $urandom_range(0, 2 * walk_step) - walk_step;
      if (walk > 32767) walk = 32767;
      if (walk < -32768) walk = -32768;
      return 16'(walk);
    end else if (r < 80) begin
      delta = tl + $urandom_range(0, 64) - 32;
      if ($urandom_range(0, 1)) delta = -delta;
      walk = delta;
      return 16'(delta);
    end
    return 16'($urandom_range(0, 65535));
  endfunction

  // Main stimulus.
  initial begin
    int quiet_start;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    quiet = 1'b0;
    ready_hold = 0;
    walk = 0;
    walk_step = 16;
    sb = new();
    for (int i = 0; i < 5; i++) cfg_vals[i] = 32'(WEIGHT_RESET);
    cfg_vals[REG_TILT_LIMIT] = 32'(TILT_RESET);
    cfg_vals[REG_RATE_LIMIT] = 32'(RATE_RESET);
    cfg_vals[REG_SIGNAL_LEVEL] = 32'(LEVEL_RESET);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part under reset settings: fill-up, extremes and both-direction trips.
    foreach (directed_pitch[k]) send_pitch(directed_pitch[k]);
    s_tvalid <= 1'b0;

    // Random phases, each under new settings written while idle.
    for (int phase = 1; phase <= 9; phase++) begin
      drain();
      pick_config(phase);
      apply_config();
      @(negedge clk);
      walk_step = $urandom_range(1, 300);
      quiet_start = $urandom_range(0, 80);
      for (int k = 0; k < 100; k++) begin
        quiet = (k >= quiet_start && k < quiet_start + 20);
        send_pitch(next_pitch());
      end
      s_tvalid <= 1'b0;
      quiet = 1'b0;
    end

    drain();
    repeat (5) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
